[src/cpbt_pkg.sv]
package cpbt_pkg;

    // sizes of the vertex store and coordinates
    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SUM_W        = COORD_W + IDX_W;
    localparam int AREA_W       = 39;
    localparam int MUL_W        = COORD_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int DIFF_W       = PROD_W + 1;
    localparam int STEP_W       = $clog2(SUM_W);
    localparam int OUT_W        = 144;

    // result kinds on m_axis_tuser
    localparam logic [1:0] RES_SUMMARY = 2'd0;
    localparam logic [1:0] RES_ANSWER  = 2'd1;
    localparam logic [1:0] RES_REJECT  = 2'd2;

    // input kinds on s_axis_tuser
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // sequencer states
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_LOAD = 12'b0000_0000_0010,
        S_LX1  = 12'b0000_0000_0100,
        S_LX2  = 12'b0000_0000_1000,
        S_CHK  = 12'b0000_0001_0000,
        S_WX1  = 12'b0000_0010_0000,
        S_WX2  = 12'b0000_0100_0000,
        S_DIV  = 12'b0000_1000_0000,
        S_EMIT = 12'b0001_0000_0000,
        S_QRD  = 12'b0010_0000_0000,
        S_QM1  = 12'b0100_0000_0000,
        S_QM2  = 12'b1000_0000_0000
    } state_t;

endpackage

[src/cpbt_ram.sv]
module cpbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/convex_polygon_builder_and_test.sv]
// Channel  | Ports           | Contents
// ---------+-----------------+---------------------------------------------------
// input    | s_axis_*        | tuser kind, tdata {y, x}, tlast last_vertex
// result   | m_axis_*        | tuser result_kind, tdata summary or query answer
//
// A vertex passes S_LOAD and S_CHK, and S_LX1 and S_LX2 for a cross product.
// The last vertex adds two products for the closing edge, a 22-step
// restoring divider run once for each centroid axis, and the hand-off to the
// output. A query walks each committed edge (S_QRD, S_QM1, S_QM2) on the
// shared 17x17 multiplier and the single read port of the vertex store.
// aresetn is synchronous, active low; the vertex store is not cleared.
// A result waits in the output register; the next item is taken meanwhile.
module convex_polygon_builder_and_test
    import cpbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // x [15:0], y [31:16]
    input  logic               s_axis_tlast,
    input  logic               s_axis_tuser,   // kind [0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // inside_res [0], twice_area [39:1], centroid_x [55:40],
    // centroid_y [71:56], box_min_x [87:72], box_min_y [103:88],
    // box_max_x [119:104], box_max_y [135:120], vertex_count [142:136],
    // overflowed [143]
    output logic [OUT_W-1:0]   m_axis_tdata,
    output logic [1:0]         m_axis_tuser    // result_kind [1:0]
);

    state_t state_reg, state_next;

    logic                      last_reg, last_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [CNT_W-1:0]          load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]          comm_cnt_reg, comm_cnt_next;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [AREA_W-1:0]         area_reg, area_next;
    logic signed [COORD_W-1:0] bminx_reg, bminx_next, bminy_reg, bminy_next;
    logic signed [COORD_W-1:0] bmaxx_reg, bmaxx_next, bmaxy_reg, bmaxy_next;
    logic                      drop_reg, drop_next;
    logic signed [COORD_W-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [COORD_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [SUM_W-1:0]          dnum_reg, dnum_next;
    logic [CNT_W-1:0]          drem_reg, drem_next;
    logic                      dneg_reg, dneg_next;
    logic [STEP_W-1:0]         dstep_reg, dstep_next;
    logic                      dpass_reg, dpass_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [1:0]                rkind_reg, rkind_next;
    logic                      rin_reg, rin_next;
    logic                      mval_reg, mval_next;
    logic [OUT_W-1:0]          mdata_reg, mdata_next;
    logic [1:0]                muser_reg, muser_next;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIFF_W-1:0] cross_d;

    // vertex store port
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [2*COORD_W-1:0]      ram_rdata;

    logic                      start, keep, is_last_edge;
    logic [CNT_W-1:0]          idx1;
    logic signed [COORD_W-1:0] sel_x, sel_y;
    logic [CNT_W:0]            rem_sh;
    logic                      qbit;
    logic [SUM_W-1:0]          qval, qsgn;

    function automatic logic signed [MUL_W-1:0] ext(input logic signed [COORD_W-1:0] v);
        ext = {v[COORD_W-1], v};
    endfunction

    function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
        mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    cpbt_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_VERTICES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (load_cnt_reg[IDX_W-1:0]),
        .wdata ({py_reg, px_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    assign start     = (load_cnt_reg == '0);
    assign keep      = (load_cnt_reg < CNT_W'(MAX_VERTICES));
    assign idx1      = {1'b0, idx_reg} + CNT_W'(1);
    assign ram_raddr = idx1[IDX_W-1:0];
    assign is_last_edge = (idx1 >= comm_cnt_reg);
    assign sel_x     = is_last_edge ? fx_reg : ram_rdata[COORD_W-1:0];
    assign sel_y     = is_last_edge ? fy_reg : ram_rdata[2*COORD_W-1:COORD_W];
    assign ram_we    = (state_reg == S_LOAD) && keep;

    // operand selection for the multiplier
    always_comb begin
        case (state_reg)
            S_LX1:   begin mul_a = ext(vx_reg); mul_b = ext(py_reg); end
            S_LX2:   begin mul_a = ext(vy_reg); mul_b = ext(px_reg); end
            S_WX1:   begin mul_a = ext(vx_reg); mul_b = ext(fy_reg); end
            S_WX2:   begin mul_a = ext(vy_reg); mul_b = ext(fx_reg); end
            S_QM1:   begin
                mul_a = ext(vx_reg) - ext(sel_x);
                mul_b = ext(vy_reg) - ext(py_reg);
            end
            S_QM2:   begin
                mul_a = ext(vy_reg) - ext(ny_reg);
                mul_b = ext(vx_reg) - ext(px_reg);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign cross_d = DIFF_W'(prod_reg) - DIFF_W'(mul_p);

    // divider step
    assign rem_sh = {drem_reg, dnum_reg[SUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, load_cnt_reg});
    assign qval   = {dnum_reg[SUM_W-2:0], qbit};
    assign qsgn   = dneg_reg ? SUM_W'(-qval) : qval;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        load_cnt_next = load_cnt_reg;
        comm_cnt_next = comm_cnt_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        area_next     = area_reg;
        bminx_next    = bminx_reg;
        bminy_next    = bminy_reg;
        bmaxx_next    = bmaxx_reg;
        bmaxy_next    = bmaxy_reg;
        drop_next     = drop_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        dnum_next     = dnum_reg;
        drem_next     = drem_reg;
        dneg_next     = dneg_reg;
        dstep_next    = dstep_reg;
        dpass_next    = dpass_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        rkind_next    = rkind_reg;
        rin_next      = rin_reg;
        mval_next     = mval_reg && !m_axis_tready;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    last_next = s_axis_tlast;
                    px_next   = s_axis_tdata[COORD_W-1:0];
                    py_next   = s_axis_tdata[2*COORD_W-1:COORD_W];
                    if (s_axis_tuser == KIND_VERTEX) begin
                        state_next = S_LOAD;
                    end else if (!start) begin
                        rkind_next = RES_REJECT;
                        rin_next   = 1'b0;
                        state_next = S_EMIT;
                    end else if (comm_cnt_reg == '0) begin
                        rkind_next = RES_ANSWER;
                        rin_next   = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        idx_next   = '0;
                        vx_next    = fx_reg;
                        vy_next    = fy_reg;
                        state_next = S_QRD;
                    end
                end
            end
            // store the vertex and update sums and box, or drop it when the store is full
            S_LOAD: begin
                if (start) begin
                    comm_cnt_next = '0;
                    area_next     = '0;
                    fx_next       = px_reg;
                    fy_next       = py_reg;
                    vx_next       = px_reg;
                    vy_next       = py_reg;
                    sum_x_next    = SUM_W'(px_reg);
                    sum_y_next    = SUM_W'(py_reg);
                    bminx_next    = px_reg;
                    bmaxx_next    = px_reg;
                    bminy_next    = py_reg;
                    bmaxy_next    = py_reg;
                    load_cnt_next = CNT_W'(1);
                    state_next    = S_CHK;
                end else if (keep) begin
                    sum_x_next    = sum_x_reg + SUM_W'(px_reg);
                    sum_y_next    = sum_y_reg + SUM_W'(py_reg);
                    if (px_reg < bminx_reg) bminx_next = px_reg;
                    if (px_reg > bmaxx_reg) bmaxx_next = px_reg;
                    if (py_reg < bminy_reg) bminy_next = py_reg;
                    if (py_reg > bmaxy_reg) bmaxy_next = py_reg;
                    load_cnt_next = load_cnt_reg + CNT_W'(1);
                    state_next    = S_LX1;
                end else begin
                    drop_next  = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_LX1: begin
                prod_next  = mul_p;
                state_next = S_LX2;
            end
            S_LX2: begin
                area_next  = area_reg + AREA_W'(cross_d);
                vx_next    = px_reg;
                vy_next    = py_reg;
                state_next = S_CHK;
            end
            S_CHK: begin
                state_next = last_reg ? S_WX1 : S_IDLE;
            end
            // closing edge, then start the x divide
            S_WX1: begin
                prod_next  = mul_p;
                state_next = S_WX2;
            end
            S_WX2: begin
                area_next  = area_reg + AREA_W'(cross_d);
                dnum_next  = mag(sum_x_reg);
                dneg_next  = sum_x_reg[SUM_W-1];
                drem_next  = '0;
                dstep_next = '0;
                dpass_next = 1'b0;
                state_next = S_DIV;
            end
            // restoring divide by the vertex count, one bit a cycle
            S_DIV: begin
                drem_next  = qbit ? CNT_W'(rem_sh - {1'b0, load_cnt_reg}) : CNT_W'(rem_sh);
                dnum_next  = qval;
                dstep_next = dstep_reg + STEP_W'(1);
                if (dstep_reg == STEP_W'(SUM_W - 1)) begin
                    if (!dpass_reg) begin
                        cx_next    = qsgn[COORD_W-1:0];
                        dnum_next  = mag(sum_y_reg);
                        dneg_next  = sum_y_reg[SUM_W-1];
                        drem_next  = '0;
                        dstep_next = '0;
                        dpass_next = 1'b1;
                    end else begin
                        cy_next    = qsgn[COORD_W-1:0];
                        rkind_next = RES_SUMMARY;
                        rin_next   = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            // hand the result to the output register
            S_EMIT: begin
                if (!mval_reg || m_axis_tready) begin
                    mval_next  = 1'b1;
                    muser_next = rkind_reg;
                    if (rkind_reg == RES_SUMMARY) begin
                        mdata_next = {drop_reg, load_cnt_reg, bmaxy_reg, bmaxx_reg,
                                      bminy_reg, bminx_reg, cy_reg, cx_reg,
                                      area_reg, 1'b0};
                        comm_cnt_next = load_cnt_reg;
                        load_cnt_next = '0;
                        drop_next     = 1'b0;
                    end else begin
                        mdata_next = {{(OUT_W-1){1'b0}}, rin_reg};
                    end
                    state_next = S_IDLE;
                end
            end
            // edge walk: read next vertex, two products, sign test
            S_QRD: begin
                state_next = S_QM1;
            end
            S_QM1: begin
                nx_next    = sel_x;
                ny_next    = sel_y;
                prod_next  = mul_p;
                state_next = S_QM2;
            end
            S_QM2: begin
                if (cross_d[DIFF_W-1]) begin
                    rkind_next = RES_ANSWER;
                    rin_next   = 1'b0;
                    state_next = S_EMIT;
                end else if (is_last_edge) begin
                    rkind_next = RES_ANSWER;
                    rin_next   = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    vx_next    = nx_reg;
                    vy_next    = ny_reg;
                    idx_next   = idx1[IDX_W-1:0];
                    state_next = S_QRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            comm_cnt_reg <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            area_reg     <= '0;
            bminx_reg    <= '0;
            bminy_reg    <= '0;
            bmaxx_reg    <= '0;
            bmaxy_reg    <= '0;
            drop_reg     <= 1'b0;
            mval_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            comm_cnt_reg <= comm_cnt_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            area_reg     <= area_next;
            bminx_reg    <= bminx_next;
            bminy_reg    <= bminy_next;
            bmaxx_reg    <= bmaxx_next;
            bmaxy_reg    <= bmaxy_next;
            drop_reg     <= drop_next;
            mval_reg     <= mval_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        dnum_reg  <= dnum_next;
        drem_reg  <= drem_next;
        dneg_reg  <= dneg_next;
        dstep_reg <= dstep_next;
        dpass_reg <= dpass_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        rkind_reg <= rkind_next;
        rin_reg   <= rin_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule
